// ----- hdl/binary_to_decimal_ascii_assert.svh -----
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_assert.svh
// Assertion macros used by the converter's top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define B2DA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed in binary_to_decimal_ascii");

// Next-cycle implication, disabled while reset is low
`define B2DA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed in binary_to_decimal_ascii");

`endif

// ----- hdl/b2da_pkg.sv -----
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared constants and types of the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

    // Width of the input field and the number of its low bits converted
    localparam int FIELD_WIDTH = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int CONV_WIDTH  = (VALUE_WIDTH < FIELD_WIDTH) ? VALUE_WIDTH : FIELD_WIDTH;

    // Decimal digits of 2^CONV_WIDTH - 1: floor(w * log10(2)) + 1
    localparam int NUM_DIGITS = ((CONV_WIDTH * 1233) >> 12) + 1;

    localparam int CNT_W  = (CONV_WIDTH > 2) ? $clog2(CONV_WIDTH) : 1;
    localparam int LEFT_W = $clog2(NUM_DIGITS + 1);

    localparam int CHAR_W = 6;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    // BCD digit code limits
    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ     = 4'd3;
    localparam logic [3:0] BCD_MAX     = 4'd9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    // Per-cycle command to every digit cell
    typedef struct packed {
        logic clear;   // zero the digit
        logic dabble;  // add-3 adjust, then shift in the neighbor's carry
        logic shift;   // take the lower neighbor's digit
    } t_cell_ctl;

endpackage

// ----- hdl/b2da_if.sv -----
// ----------------------------------------------------------------------------
// b2da_in_if / b2da_out_if
// Valid/ready channels for input numbers and output characters.
// ----------------------------------------------------------------------------
interface b2da_in_if;
    logic                             valid;
    logic                             ready;
    logic [b2da_pkg::FIELD_WIDTH-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface b2da_out_if;
    logic                        valid;
    logic                        ready;
    logic [b2da_pkg::CHAR_W-1:0] digit_char;
    logic                        last_digit;

    modport source (output valid, output digit_char, output last_digit, input ready);
    modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

// ----- hdl/b2da_cell.sv -----
// ----------------------------------------------------------------------------
// b2da_cell
// One BCD digit of the double-dabble chain; also shifts digits out.
// ----------------------------------------------------------------------------
module b2da_cell (
    input  logic                i_clk,
    input  b2da_pkg::t_cell_ctl i_ctl,
    input  logic                i_carry,
    input  logic [3:0]          i_digit,
    output logic                o_carry,
    output logic [3:0]          o_digit
);

    logic [3:0] r_digit;
    logic [3:0] w_adj;

    // Add 3 when the digit would overflow after doubling
    assign w_adj   = (r_digit >= b2da_pkg::BCD_ADJ_MIN) ? (r_digit + b2da_pkg::BCD_ADJ)
                                                        : r_digit;
    assign o_carry = w_adj[3];
    assign o_digit = r_digit;

    // Digit register
    always_ff @(posedge i_clk) begin
        priority if (i_ctl.clear) begin
            r_digit <= 4'd0;
        end else if (i_ctl.dabble) begin
            r_digit <= {w_adj[2:0], i_carry};
        end else if (i_ctl.shift) begin
            r_digit <= i_digit;
        end else begin
            r_digit <= r_digit;
        end
    end

endmodule

// ----- hdl/binary_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: 32-bit unsigned number to decimal ASCII digits
// Flow: an item is accepted in idle, then the digit chain runs the shift-add
//   conversion over all CONV_WIDTH (32) input bits, then emits the digits,
//   skipping leading zeros. No new item is accepted until the last digit.
//   The emit phase steps one digit per cycle out of the chain while the
//   output slot is free (output register empty or taken by the sink).
// Reset: synchronous active-low; clears the FSM and output valid.
// ----------------------------------------------------------------------------
`include "binary_to_decimal_ascii_assert.svh"

module binary_to_decimal_ascii (
    input  logic       i_clk,
    input  logic       i_rst_n,
    b2da_in_if.sink    i_in,
    b2da_out_if.source o_out
);

    localparam int ND = b2da_pkg::NUM_DIGITS;
    localparam int CW = b2da_pkg::CONV_WIDTH;

    b2da_pkg::t_state    r_state, n_state;
    b2da_pkg::t_cell_ctl w_ctl;

    logic [CW-1:0]                   r_bin;
    logic [b2da_pkg::CNT_W-1:0]      r_cnt;
    logic [b2da_pkg::LEFT_W-1:0]     r_left;
    logic                            r_started;
    logic                            r_out_valid;
    logic [b2da_pkg::CHAR_W-1:0]     r_out_char;
    logic                            r_out_last;

    logic [ND-1:0]      w_carry;
    logic [ND-1:0][3:0] w_dig;
    logic               w_accept;
    logic               w_slot_free;
    logic               w_step;
    logic               w_is_last;
    logic               w_show;
    logic               w_conv_done;
    logic               w_dig_ok;
    logic [3:0]         w_top;

    // Digit cell chain: cell 0 is least significant
    for (genvar k = 0; k < ND; k++) begin : g_cell
        logic       w_cin;
        logic [3:0] w_din;
        if (k == 0) begin : g_first
            assign w_cin = r_bin[CW-1];
            assign w_din = 4'd0;
        end else begin : g_rest
            assign w_cin = w_carry[k-1];
            assign w_din = w_dig[k-1];
        end
        b2da_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_carry (w_cin),
            .i_digit (w_din),
            .o_carry (w_carry[k]),
            .o_digit (w_dig[k])
        );
    end

    // Handshake and emit qualifiers
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_slot_free = !r_out_valid || o_out.ready;
    assign w_top       = w_dig[ND-1];
    assign w_is_last   = (r_left == b2da_pkg::LEFT_W'(1));
    assign w_show      = (w_top != 4'd0) || r_started || w_is_last;
    assign w_step      = (r_state == b2da_pkg::ST_EMIT) && w_slot_free;
    assign w_conv_done = (r_state == b2da_pkg::ST_CONV) && (r_cnt == '0);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            b2da_pkg::ST_IDLE: begin
                if (i_in.valid) n_state = b2da_pkg::ST_CONV;
            end
            b2da_pkg::ST_CONV: begin
                if (r_cnt == '0) n_state = b2da_pkg::ST_EMIT;
            end
            b2da_pkg::ST_EMIT: begin
                if (w_slot_free && w_is_last) n_state = b2da_pkg::ST_IDLE;
            end
            default: n_state = b2da_pkg::ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        i_in.ready   = (r_state == b2da_pkg::ST_IDLE);
        w_ctl.clear  = w_accept;
        w_ctl.dabble = (r_state == b2da_pkg::ST_CONV);
        w_ctl.shift  = w_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= b2da_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Binary shifter and step counters
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bin     <= i_in.number[CW-1:0];
            r_cnt     <= b2da_pkg::CNT_W'(CW - 1);
            r_started <= 1'b0;
        end else if (r_state == b2da_pkg::ST_CONV) begin
            r_bin <= {r_bin[CW-2:0], 1'b0};
            r_cnt <= r_cnt - b2da_pkg::CNT_W'(1);
        end
        if (w_conv_done) begin
            r_left <= b2da_pkg::LEFT_W'(ND);
        end else if (w_step) begin
            r_left <= r_left - b2da_pkg::LEFT_W'(1);
            if (w_show) r_started <= 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_show) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_step && w_show) begin
            r_out_char <= b2da_pkg::ASCII_ZERO | {{(b2da_pkg::CHAR_W-4){1'b0}}, w_top};
            r_out_last <= w_is_last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.digit_char = r_out_char;
    assign o_out.last_digit = r_out_last;

    // Every cell holds a legal BCD code
    always_comb begin
        w_dig_ok = 1'b1;
        for (int k = 0; k < ND; k++) begin
            if (w_dig[k] > b2da_pkg::BCD_MAX) w_dig_ok = 1'b0;
        end
    end

    `B2DA_ASSERT_NEXT(a_accept_starts_conv, i_clk, i_rst_n, w_accept, r_state == b2da_pkg::ST_CONV)
    `B2DA_ASSERT_NOW(a_emit_has_digits, i_clk, i_rst_n, r_state == b2da_pkg::ST_EMIT, r_left != '0)
    `B2DA_ASSERT_NEXT(a_last_ends_run, i_clk, i_rst_n, w_step && w_is_last, r_state == b2da_pkg::ST_IDLE && r_out_valid && r_out_last)
    `B2DA_ASSERT_NOW(a_bcd_legal, i_clk, i_rst_n, r_state == b2da_pkg::ST_EMIT, w_dig_ok)

endmodule
